/* rtl/core/three_anchor_trilateration_defines.svh */
// Assertion macros shared by the checker of the trilateration block.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef THREE_ANCHOR_TRILATERATION_DEFINES_SVH
`define THREE_ANCHOR_TRILATERATION_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define TAT_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("trilateration port check failed");

// Next-cycle implication, active during reset as well.
`define TAT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("trilateration port check failed");

`endif

/* rtl/core/tat_pkg.sv */
// Shared widths, status codes and stage payload types of the trilateration block.
// Used by every RTL module and by the port checker; depends on nothing.
package tat_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int FRACTION_BITS = 8;
  localparam int HEIGHT_W      = 16;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(3 << FRACTION_BITS);

  localparam int SQ_W   = 2 * COORD_WIDTH;          // range squared
  localparam int XSQ_W  = SQ_W - 1;                 // coordinate squared
  localparam int H2_W   = 2 * HEIGHT_W;             // height squared
  localparam int DIFF_W = COORD_WIDTH + 1;          // coordinate difference
  localparam int LIN_W  = 2 * COORD_WIDTH + 2;      // right-hand side of the system
  localparam int LO_W   = DIFF_W;                   // low slice of a right-hand side
  localparam int HI_W   = LIN_W - LO_W;             // high slice of a right-hand side
  localparam int HP_W   = HI_W + DIFF_W;            // high partial product
  localparam int LP_W   = LO_W + 1 + DIFF_W;        // low partial product
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DET_W  = PROD_W + 1;
  localparam int DEN_W  = DET_W + 1;
  localparam int NUM_W  = LIN_W + DIFF_W + 1;
  localparam int REM_W  = NUM_W + 1;
  localparam int QUO_W  = COORD_WIDTH;
  localparam int IN_W   = 9 * COORD_WIDTH;
  localparam int OUT_W  = 2 * COORD_WIDTH;
  localparam int NPROD  = 4;

  localparam logic [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] POS_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_COLLINEAR = 2'd1,
    STATUS_SATURATED = 2'd2,
    STATUS_CLAMPED   = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] slant_range;
    logic [2:0][COORD_WIDTH-1:0] anchor_x;
    logic [2:0][COORD_WIDTH-1:0] anchor_y;
  } item_t;

  typedef struct packed {
    logic [LIN_W-1:0]  lin_a;
    logic [LIN_W-1:0]  lin_b;
    logic [DIFF_W-1:0] a11;
    logic [DIFF_W-1:0] a12;
    logic [DIFF_W-1:0] a21;
    logic [DIFF_W-1:0] a22;
    logic [DET_W-1:0]  det;
    logic              clamped;
  } front_out_t;

  typedef struct packed {
    logic [NUM_W-1:0] mag_x;
    logic [NUM_W-1:0] mag_y;
    logic [DEN_W-1:0] mag_den;
    logic             neg_x;
    logic             neg_y;
    logic             collinear;
    logic             clamped;
  } div_in_t;

  typedef struct packed {
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
    logic             ovf_x;
    logic             ovf_y;
    logic             neg_x;
    logic             neg_y;
    logic             collinear;
    logic             clamped;
  } div_stage_t;

  // Difference of two coordinates, one bit wider so it never wraps.
  function automatic logic [DIFF_W-1:0] coord_diff(logic [COORD_WIDTH-1:0] p,
                                                   logic [COORD_WIDTH-1:0] q);
    return {p[COORD_WIDTH-1], p} - {q[COORD_WIDTH-1], q};
  endfunction

endpackage

/* rtl/core/tat_front.sv */
// Front end of the trilateration pipeline: squares, plane distances, linear system.
// Three register stages; uses tat_pkg.
module tat_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [tat_pkg::HEIGHT_W-1:0]   height,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tat_pkg::item_t                 in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tat_pkg::front_out_t            out_data
);

  // Stage 1: squares and coordinate differences.
  logic                                v1;
  logic [tat_pkg::SQ_W-1:0]            rsq [3];
  logic [tat_pkg::XSQ_W-1:0]           xsq [3];
  logic [tat_pkg::XSQ_W-1:0]           ysq [3];
  logic [tat_pkg::H2_W-1:0]            hsq;
  logic signed [tat_pkg::DIFF_W-1:0]   s1_a11, s1_a12, s1_a21, s1_a22;
  logic signed [tat_pkg::SQ_W-1:0]     xsq_full [3];
  logic signed [tat_pkg::SQ_W-1:0]     ysq_full [3];

  // Stage 2: plane distances, sums of squares, determinant products.
  logic                                v2;
  logic [tat_pkg::SQ_W-1:0]            plane_d [3];
  logic [tat_pkg::SQ_W-1:0]            plane_d_next [3];
  logic                                clamp_next, s2_clamped;
  logic [tat_pkg::LIN_W-1:0]           sum_a, sum_b;
  logic signed [tat_pkg::PROD_W-1:0]   prod_1, prod_2;
  logic signed [tat_pkg::DIFF_W-1:0]   s2_a11, s2_a12, s2_a21, s2_a22;

  logic en1, en2, en3;

  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xsq_full[i] = $signed(in_item.anchor_x[i]) * $signed(in_item.anchor_x[i]);
      ysq_full[i] = $signed(in_item.anchor_y[i]) * $signed(in_item.anchor_y[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        rsq[i] <= tat_pkg::SQ_W'(in_item.slant_range[i]) *
                  tat_pkg::SQ_W'(in_item.slant_range[i]);
        xsq[i] <= xsq_full[i][tat_pkg::XSQ_W-1:0];
        ysq[i] <= ysq_full[i][tat_pkg::XSQ_W-1:0];
      end
      hsq    <= tat_pkg::H2_W'(height) * tat_pkg::H2_W'(height);
      s1_a11 <= tat_pkg::coord_diff(in_item.anchor_x[2], in_item.anchor_x[1]);
      s1_a12 <= tat_pkg::coord_diff(in_item.anchor_y[2], in_item.anchor_y[1]);
      s1_a21 <= tat_pkg::coord_diff(in_item.anchor_x[1], in_item.anchor_x[0]);
      s1_a22 <= tat_pkg::coord_diff(in_item.anchor_y[1], in_item.anchor_y[0]);
    end
  end

  always_comb begin
    clamp_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (rsq[i] >= tat_pkg::SQ_W'(hsq)) begin
        plane_d_next[i] = rsq[i] - tat_pkg::SQ_W'(hsq);
      end else begin
        plane_d_next[i] = '0;
        clamp_next      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      plane_d    <= plane_d_next;
      s2_clamped <= clamp_next;
      sum_a      <= tat_pkg::LIN_W'(xsq[2]) - tat_pkg::LIN_W'(xsq[1]) +
                    tat_pkg::LIN_W'(ysq[2]) - tat_pkg::LIN_W'(ysq[1]);
      sum_b      <= tat_pkg::LIN_W'(xsq[1]) - tat_pkg::LIN_W'(xsq[0]) +
                    tat_pkg::LIN_W'(ysq[1]) - tat_pkg::LIN_W'(ysq[0]);
      prod_1     <= s1_a11 * s1_a22;
      prod_2     <= s1_a12 * s1_a21;
      s2_a11     <= s1_a11;
      s2_a12     <= s1_a12;
      s2_a21     <= s1_a21;
      s2_a22     <= s1_a22;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_data.lin_a   <= tat_pkg::LIN_W'(plane_d[1]) - tat_pkg::LIN_W'(plane_d[2]) + sum_a;
      out_data.lin_b   <= tat_pkg::LIN_W'(plane_d[0]) - tat_pkg::LIN_W'(plane_d[1]) + sum_b;
      out_data.det     <= tat_pkg::DET_W'(prod_1) - tat_pkg::DET_W'(prod_2);
      out_data.a11     <= s2_a11;
      out_data.a12     <= s2_a12;
      out_data.a21     <= s2_a21;
      out_data.a22     <= s2_a22;
      out_data.clamped <= s2_clamped;
    end
  end

endmodule

/* rtl/core/tat_cramer.sv */
// Cramer numerators of the trilateration pipeline, split into narrow partial products.
// Four register stages; uses tat_pkg.
module tat_cramer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tat_pkg::front_out_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tat_pkg::div_in_t      out_data
);

  // Product k is lin[k] * coef[k]: a*a22, b*a12, b*a11, a*a21.
  logic [tat_pkg::LIN_W-1:0]          lin_sel  [tat_pkg::NPROD];
  logic signed [tat_pkg::DIFF_W-1:0]  coef_sel [tat_pkg::NPROD];

  logic                               v1, v2, v3;
  logic signed [tat_pkg::HP_W-1:0]    hi_part [tat_pkg::NPROD];
  logic signed [tat_pkg::LP_W-1:0]    lo_part [tat_pkg::NPROD];
  logic signed [tat_pkg::NUM_W-1:0]   full    [tat_pkg::NPROD];
  logic signed [tat_pkg::NUM_W-1:0]   num_x, num_y;
  logic [tat_pkg::DET_W-1:0]          det1, det2, det3;
  logic                               clamp1, clamp2, clamp3;
  logic [tat_pkg::DET_W-1:0]          det_mag;
  logic en1, en2, en3, en4;

  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_comb begin
    lin_sel[0]  = in_data.lin_a;
    lin_sel[1]  = in_data.lin_b;
    lin_sel[2]  = in_data.lin_b;
    lin_sel[3]  = in_data.lin_a;
    coef_sel[0] = $signed(in_data.a22);
    coef_sel[1] = $signed(in_data.a12);
    coef_sel[2] = $signed(in_data.a11);
    coef_sel[3] = $signed(in_data.a21);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  // Stage 1: high slice is signed, low slice is an unsigned magnitude.
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < tat_pkg::NPROD; k++) begin
        hi_part[k] <= $signed(lin_sel[k][tat_pkg::LIN_W-1:tat_pkg::LO_W]) * coef_sel[k];
        lo_part[k] <= $signed({1'b0, lin_sel[k][tat_pkg::LO_W-1:0]}) * coef_sel[k];
      end
      det1   <= in_data.det;
      clamp1 <= in_data.clamped;
    end
  end

  // Stage 2: recombine the slices into full products.
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < tat_pkg::NPROD; k++) begin
        full[k] <= (tat_pkg::NUM_W'(hi_part[k]) <<< tat_pkg::LO_W) +
                   tat_pkg::NUM_W'(lo_part[k]);
      end
      det2   <= det1;
      clamp2 <= clamp1;
    end
  end

  // Stage 3: numerators.
  always_ff @(posedge clk) begin
    if (en3) begin
      num_x  <= full[0] - full[1];
      num_y  <= full[2] - full[3];
      det3   <= det2;
      clamp3 <= clamp2;
    end
  end

  assign det_mag = det3[tat_pkg::DET_W-1] ? -det3 : det3;

  // Stage 4: magnitudes and signs for the divider; denominator is twice det.
  always_ff @(posedge clk) begin
    if (en4) begin
      out_data.mag_x     <= num_x[tat_pkg::NUM_W-1] ? -num_x : num_x;
      out_data.mag_y     <= num_y[tat_pkg::NUM_W-1] ? -num_y : num_y;
      out_data.mag_den   <= {det_mag, 1'b0};
      out_data.neg_x     <= num_x[tat_pkg::NUM_W-1] ^ det3[tat_pkg::DET_W-1];
      out_data.neg_y     <= num_y[tat_pkg::NUM_W-1] ^ det3[tat_pkg::DET_W-1];
      out_data.collinear <= (det3 == '0);
      out_data.clamped   <= clamp3;
    end
  end

endmodule

/* rtl/core/tat_divider.sv */
// Pipelined restoring divider for both coordinates, one quotient bit per stage.
// An overflow check stage plus QUO_W step stages; uses tat_pkg.
module tat_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tat_pkg::div_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tat_pkg::div_stage_t  out_data
);

  tat_pkg::div_stage_t st [tat_pkg::QUO_W+1];
  logic                v  [tat_pkg::QUO_W+1];
  logic                en [tat_pkg::QUO_W+1];
  logic [tat_pkg::REM_W-1:0] den_top;

  // A quotient that would not fit in QUO_W bits saturates anyway.
  assign den_top = tat_pkg::REM_W'(in_data.mag_den) << tat_pkg::QUO_W;

  assign en[tat_pkg::QUO_W] = !v[tat_pkg::QUO_W] || out_ready;
  assign in_ready  = en[0];
  assign out_valid = v[tat_pkg::QUO_W];
  assign out_data  = st[tat_pkg::QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0].rem_x     <= tat_pkg::REM_W'(in_data.mag_x);
      st[0].rem_y     <= tat_pkg::REM_W'(in_data.mag_y);
      st[0].den       <= in_data.mag_den;
      st[0].quo_x     <= '0;
      st[0].quo_y     <= '0;
      st[0].ovf_x     <= tat_pkg::REM_W'(in_data.mag_x) >= den_top;
      st[0].ovf_y     <= tat_pkg::REM_W'(in_data.mag_y) >= den_top;
      st[0].neg_x     <= in_data.neg_x;
      st[0].neg_y     <= in_data.neg_y;
      st[0].collinear <= in_data.collinear;
      st[0].clamped   <= in_data.clamped;
    end
  end

  for (genvar k = 0; k < tat_pkg::QUO_W; k++) begin : g_step
    localparam int SH = tat_pkg::QUO_W - 1 - k;
    logic [tat_pkg::REM_W-1:0] den_sh;
    logic                      take_x, take_y;
    tat_pkg::div_stage_t       st_next;

    assign den_sh = tat_pkg::REM_W'(st[k].den) << SH;
    assign take_x = st[k].rem_x >= den_sh;
    assign take_y = st[k].rem_y >= den_sh;
    assign en[k]  = !v[k] || en[k+1];

    always_comb begin
      st_next           = st[k];
      st_next.rem_x     = take_x ? st[k].rem_x - den_sh : st[k].rem_x;
      st_next.rem_y     = take_y ? st[k].rem_y - den_sh : st[k].rem_y;
      st_next.quo_x[SH] = take_x;
      st_next.quo_y[SH] = take_y;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en[k+1]) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k+1]) begin
        st[k+1] <= st_next;
      end
    end
  end

endmodule

/* rtl/core/three_anchor_trilateration.sv */
// Top level of the three-anchor 2D trilateration block.
// Instantiates tat_front, tat_cramer and tat_divider; uses tat_pkg.
//
// Usage: one item on the slave stream carries three slant ranges and three anchor
// positions; one item on the master stream returns the solved position and a
// status code. Ranges are reduced by the anchor height, which is set through the
// cfg channel (always ready, reset value 3 m). Write the height only while no item
// is in flight.
// From input accept to output valid, an item passes three front-end stages, four
// Cramer stages, one overflow-check stage and 24 divider stages (one quotient bit
// each), and the output register.
// Throughput is one item per clock while the output is not stalled; the divider chain sets the depth.
// Every stage carries its own valid bit. When the receiver holds m_axis_tready low,
// the pipeline keeps filling its empty stages, so s_axis_tready stays high until
// the stall reaches the input. No item is lost or repeated.
// Reset (rst, synchronous, active high) clears all valid bits and restores the
// anchor height; the output stream shows no valid item in the cycle after reset.
module three_anchor_trilateration (
  input  logic                          clk,
  input  logic                          rst,
  // Slave stream, tdata from the lowest bit up: slant_range_0, slant_range_1,
  // slant_range_2, anchor_x_0, anchor_y_0, anchor_x_1, anchor_y_1, anchor_x_2,
  // anchor_y_2 (24 bits each).
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tat_pkg::IN_W-1:0]      s_axis_tdata,
  // Master stream, tdata from the lowest bit up: position_x, position_y.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tat_pkg::OUT_W-1:0]     m_axis_tdata,
  // tuser: fix_status (2 bits).
  output logic [1:0]                    m_axis_tuser,
  // Anchor height register write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tat_pkg::HEIGHT_W-1:0]  cfg_data
);

  localparam int CW = tat_pkg::COORD_WIDTH;

  logic [tat_pkg::HEIGHT_W-1:0] height;
  tat_pkg::item_t               item;
  logic                         front_valid, front_ready;
  tat_pkg::front_out_t          front_data;
  logic                         cram_valid, cram_ready;
  tat_pkg::div_in_t             cram_data;
  logic                         div_valid, div_ready;
  tat_pkg::div_stage_t          div_data;

  logic [CW-1:0]    lim_x, lim_y, mag_x, mag_y;
  logic             sat_x, sat_y, out_en;
  tat_pkg::status_t status_next;
  logic [CW-1:0]    pos_x_next, pos_y_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      height <= tat_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      height <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item.slant_range[i] = s_axis_tdata[i*CW +: CW];
      item.anchor_x[i]    = s_axis_tdata[(3 + 2*i)*CW +: CW];
      item.anchor_y[i]    = s_axis_tdata[(4 + 2*i)*CW +: CW];
    end
  end

  tat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .height    (height),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (item),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  tat_cramer u_cramer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (cram_valid),
    .out_ready (cram_ready),
    .out_data  (cram_data)
  );

  tat_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cram_valid),
    .in_ready  (cram_ready),
    .in_data   (cram_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  // Saturation: a negative result may reach one step further than a positive one.
  always_comb begin
    lim_x = div_data.neg_x ? tat_pkg::POS_MIN : tat_pkg::POS_MAX;
    lim_y = div_data.neg_y ? tat_pkg::POS_MIN : tat_pkg::POS_MAX;
    sat_x = div_data.ovf_x || (div_data.quo_x > lim_x);
    sat_y = div_data.ovf_y || (div_data.quo_y > lim_y);
    mag_x = sat_x ? lim_x : div_data.quo_x;
    mag_y = sat_y ? lim_y : div_data.quo_y;
    // Collinear anchors win over every other code and zero the position.
    priority if (div_data.collinear) begin
      pos_x_next  = '0;
      pos_y_next  = '0;
      status_next = tat_pkg::STATUS_COLLINEAR;
    end else if (sat_x || sat_y) begin
      pos_x_next  = div_data.neg_x ? -mag_x : mag_x;
      pos_y_next  = div_data.neg_y ? -mag_y : mag_y;
      status_next = tat_pkg::STATUS_SATURATED;
    end else if (div_data.clamped) begin
      pos_x_next  = div_data.neg_x ? -mag_x : mag_x;
      pos_y_next  = div_data.neg_y ? -mag_y : mag_y;
      status_next = tat_pkg::STATUS_CLAMPED;
    end else begin
      pos_x_next  = div_data.neg_x ? -mag_x : mag_x;
      pos_y_next  = div_data.neg_y ? -mag_y : mag_y;
      status_next = tat_pkg::STATUS_OK;
    end
  end

  assign out_en    = !m_axis_tvalid || m_axis_tready;
  assign div_ready = out_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_en) begin
      m_axis_tvalid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      m_axis_tdata <= {pos_y_next, pos_x_next};
      m_axis_tuser <= status_next;
    end
  end

endmodule

/* rtl/core/tat_checker.sv */
// Port-level checker of the trilateration block, bound to the top level.
// Uses tat_pkg and the macros of three_anchor_trilateration_defines.svh.
`include "three_anchor_trilateration_defines.svh"

module tat_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tat_pkg::OUT_W-1:0]     m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);

  localparam int CW = tat_pkg::COORD_WIDTH;

  logic [CW-1:0] pos_x, pos_y;
  logic          is_coll, is_sat, at_limit;

  assign pos_x    = m_axis_tdata[CW-1:0];
  assign pos_y    = m_axis_tdata[2*CW-1:CW];
  assign is_coll  = m_axis_tvalid && (m_axis_tuser == tat_pkg::STATUS_COLLINEAR);
  assign is_sat   = m_axis_tvalid && (m_axis_tuser == tat_pkg::STATUS_SATURATED);
  assign at_limit = (pos_x == tat_pkg::POS_MAX) || (pos_x == tat_pkg::POS_MIN) ||
                    (pos_y == tat_pkg::POS_MAX) || (pos_y == tat_pkg::POS_MIN);

  // A stalled result stays offered.
  `TAT_ASSERT_NEXT(a_hold, !rst && m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // Reset empties the pipeline.
  `TAT_ASSERT_NEXT(a_reset_empty, rst, !m_axis_tvalid)

  // Collinear anchors give a zero position.
  `TAT_ASSERT_IMPL(a_collinear_zero, is_coll, m_axis_tdata == '0)

  // A saturated result has at least one coordinate at a limit.
  `TAT_ASSERT_IMPL(a_sat_limit, is_sat, at_limit)

endmodule

bind three_anchor_trilateration tat_checker u_tat_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
